>>> sv/amap_pkg.sv
// Shared types, constants and helpers for the accelerometer moving-average pixel unit.
package amap_pkg;

    localparam int WINDOW_LEN_DEF = 25;
    localparam int SCREEN_W_DEF   = 640;
    localparam int SCREEN_H_DEF   = 480;

    localparam int SMP_W  = 16;
    localparam int Q_W    = 24;
    localparam int GAIN_W = 24;

    localparam logic [GAIN_W-1:0] GAIN_RST = 24'd65536;

    localparam int Q_MAX = 8388607;
    localparam int Q_MIN = -8388608;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        CFG_GAIN,
        CFG_TRIM_X,
        CFG_TRIM_Y,
        CFG_TRIM_Z
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_CAL,
        S_PIX,
        S_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_LOAD,
        C_DIV,
        C_TRIM
    } t_cal_state;

    typedef struct packed {
        logic start;
        logic update;
    } t_win_ctl;

    // Width of a signed running sum over a window of len samples.
    function automatic int sum_width(input int len);
        return SMP_W + 1 + $clog2(len);
    endfunction

endpackage

>>> sv/amap_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module amap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/amap_window.sv
// Sample window memory with per-entry valid bits, write pointer and running axis sums.
module amap_window #(
    parameter int WINDOW_LEN = amap_pkg::WINDOW_LEN_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  amap_pkg::t_win_ctl                              i_ctl,
    input  logic signed [amap_pkg::SMP_W-1:0]               i_sample_x,
    input  logic signed [amap_pkg::SMP_W-1:0]               i_sample_y,
    input  logic signed [amap_pkg::SMP_W-1:0]               i_sample_z,
    output logic signed [amap_pkg::sum_width(WINDOW_LEN)-1:0] o_sum [3]
);
    import amap_pkg::*;

    localparam int SUM_W  = sum_width(WINDOW_LEN);
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ENT_W  = 3 * SMP_W;

    logic [SLOT_W-1:0]           r_slot;
    logic [WINDOW_LEN-1:0]       r_vld;
    logic signed [SMP_W-1:0]     r_smp [3];
    logic signed [SUM_W-1:0]     r_sum [3];
    logic signed [SUM_W-1:0]     n_sum [3];
    logic [ENT_W-1:0]            rd_data;
    logic [ENT_W-1:0]            wr_data;
    logic signed [SMP_W-1:0]     old_smp [3];
    logic [SLOT_W-1:0]           n_slot;

    assign wr_data = {r_smp[2], r_smp[1], r_smp[0]};

    amap_ram #(
        .WIDTH(ENT_W),
        .DEPTH(WINDOW_LEN)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.update),
        .i_waddr(r_slot),
        .i_wdata(wr_data),
        .i_re   (i_ctl.start),
        .i_raddr(r_slot),
        .o_rdata(rd_data)
    );

    // An entry never written since reset is read as a zero sample.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            old_smp[a] = r_vld[r_slot] ? $signed(rd_data[a*SMP_W +: SMP_W]) : '0;
            n_sum[a]   = r_sum[a] - SUM_W'(old_smp[a]) + SUM_W'(r_smp[a]);
        end
        n_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_smp[0] <= i_sample_x;
            r_smp[1] <= i_sample_y;
            r_smp[2] <= i_sample_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_vld  <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else if (i_ctl.update) begin
            r_slot         <= n_slot;
            r_vld[r_slot]  <= 1'b1;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= n_sum[a];
            end
        end
    end

    assign o_sum = r_sum;

endmodule

>>> sv/amap_calib.sv
// Per-axis calibration: shared multiplier, radix-256 long division by the window length, trim and clamp.
module amap_calib #(
    parameter int WINDOW_LEN = amap_pkg::WINDOW_LEN_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [amap_pkg::GAIN_W-1:0]                       i_gain,
    input  logic signed [amap_pkg::Q_W-1:0]                   i_trim [3],
    input  logic signed [amap_pkg::sum_width(WINDOW_LEN)-1:0] i_sum [3],
    output logic signed [amap_pkg::Q_W-1:0]                   o_g [3],
    output logic                                              o_done
);
    import amap_pkg::*;

    localparam int SUM_W   = sum_width(WINDOW_LEN);
    localparam int PROD_W  = SUM_W + GAIN_W + 1;
    localparam int N_W     = PROD_W - 8;
    localparam int W_BITS  = $clog2(WINDOW_LEN + 1);
    localparam int DIV_W   = N_W + W_BITS;
    localparam int DIGITS  = (DIV_W + 7) / 8;
    localparam int DIV_PAD = DIGITS * 8;
    localparam int CNT_W   = $clog2(DIGITS + 1);

    localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(DIGITS - 1);
    localparam logic [W_BITS:0]     DIVISOR  = (W_BITS + 1)'(WINDOW_LEN);
    localparam logic [DIV_PAD-1:0]  OFFSET   = DIV_PAD'(WINDOW_LEN) << (N_W - 1);
    localparam logic signed [N_W:0] LIM_HI   = (N_W + 1)'(Q_MAX);
    localparam logic signed [N_W:0] LIM_LO   = (N_W + 1)'(Q_MIN);

    t_cal_state                r_state, n_state;
    logic [1:0]                r_axis;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [PROD_W-1:0]  r_prod;
    logic [DIV_PAD-1:0]        r_num;
    logic [DIV_PAD-1:0]        r_quo;
    logic [W_BITS-1:0]         r_rem;
    logic signed [Q_W-1:0]     r_g [3];

    logic                      mul_en, load_en, div_en, trim_en;
    logic signed [SUM_W-1:0]   sum_sel;
    logic signed [Q_W-1:0]     trim_sel;
    logic signed [N_W-1:0]     n_div;
    logic [DIV_PAD-1:0]        d_num, d_quo;
    logic [W_BITS-1:0]         d_rem;
    logic [W_BITS:0]           d_trial;
    logic signed [N_W-1:0]     quo_s;
    logic signed [N_W:0]       cal_sum;
    logic signed [Q_W-1:0]     cal_sat;

    always_comb begin
        case (r_axis)
            AXIS_X:  begin sum_sel = i_sum[0]; trim_sel = i_trim[0]; end
            AXIS_Y:  begin sum_sel = i_sum[1]; trim_sel = i_trim[1]; end
            default: begin sum_sel = i_sum[2]; trim_sel = i_trim[2]; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_start) n_state = C_MUL;
            C_MUL:   n_state = C_LOAD;
            C_LOAD:  n_state = C_DIV;
            C_DIV:   if (r_cnt == CNT_LAST) n_state = C_TRIM;
            C_TRIM:  n_state = (r_axis == AXIS_Z) ? C_IDLE : C_MUL;
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        mul_en  = (r_state == C_MUL);
        load_en = (r_state == C_LOAD);
        div_en  = (r_state == C_DIV);
        trim_en = (r_state == C_TRIM);
        o_done  = (r_state == C_TRIM) && (r_axis == AXIS_Z);
    end

    // The offset makes the dividend non-negative, so floor division becomes plain long division.
    assign n_div = r_prod[PROD_W-1:8];

    always_comb begin
        d_num   = r_num;
        d_quo   = r_quo;
        d_rem   = r_rem;
        d_trial = '0;
        for (int j = 0; j < 8; j++) begin
            d_trial = {d_rem, d_num[DIV_PAD-1]};
            d_num   = {d_num[DIV_PAD-2:0], 1'b0};
            if (d_trial >= DIVISOR) begin
                d_rem = W_BITS'(d_trial - DIVISOR);
                d_quo = {d_quo[DIV_PAD-2:0], 1'b1};
            end else begin
                d_rem = d_trial[W_BITS-1:0];
                d_quo = {d_quo[DIV_PAD-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        quo_s   = $signed({~r_quo[N_W-1], r_quo[N_W-2:0]});
        cal_sum = (N_W + 1)'(quo_s) + (N_W + 1)'(trim_sel);
        if (cal_sum > LIM_HI) begin
            cal_sat = Q_W'(LIM_HI);
        end else if (cal_sum < LIM_LO) begin
            cal_sat = Q_W'(LIM_LO);
        end else begin
            cal_sat = cal_sum[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_axis  <= AXIS_X;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == C_IDLE) begin
                r_axis <= AXIS_X;
            end else if (trim_en) begin
                r_axis <= r_axis + 2'd1;
            end
            if (load_en) begin
                r_cnt <= '0;
            end else if (div_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= sum_sel * $signed({1'b0, i_gain});
        end
        if (load_en) begin
            r_num <= DIV_PAD'(n_div) + OFFSET;
            r_quo <= '0;
            r_rem <= '0;
        end else if (div_en) begin
            r_num <= d_num;
            r_quo <= d_quo;
            r_rem <= d_rem;
        end
        if (trim_en) begin
            case (r_axis)
                AXIS_X:  r_g[0] <= cal_sat;
                AXIS_Y:  r_g[1] <= cal_sat;
                default: r_g[2] <= cal_sat;
            endcase
        end
    end

    assign o_g = r_g;

endmodule

>>> sv/amap_pixmap.sv
// Maps a calibrated acceleration to a screen coordinate around the center, clamped to the screen.
module amap_pixmap #(
    parameter int SPAN = amap_pkg::SCREEN_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic signed [amap_pkg::Q_W-1:0]  i_g,
    output logic [$clog2(SPAN)-1:0]          o_pix
);
    import amap_pkg::*;

    localparam int HALF = SPAN / 2;
    localparam int HB   = $clog2(HALF + 1);
    localparam int PW   = Q_W + HB + 1;
    localparam int SW   = PW - 16;
    localparam int OW   = $clog2(SPAN);

    localparam logic signed [HB:0] HALF_S = (HB + 1)'(HALF);
    localparam logic signed [SW:0] HALF_P = (SW + 1)'(HALF);
    localparam logic signed [SW:0] P_MAX  = (SW + 1)'(SPAN - 1);

    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] shifted;
    logic signed [SW:0]   pos;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_g * HALF_S;
        end
    end

    always_comb begin
        shifted = r_prod[PW-1:16];
        pos     = (SW + 1)'(shifted) + HALF_P;
        if (pos < 0) begin
            o_pix = '0;
        end else if (pos > P_MAX) begin
            o_pix = OW'(SPAN - 1);
        end else begin
            o_pix = pos[OW-1:0];
        end
    end

endmodule

>>> sv/accel_moving_average_to_pixel_unit.sv
// Top level of the accelerometer moving-average filter with crosshair and display outputs.
//
//   Channel   Direction  Handshake           Payload
//   sample    in         i_valid / o_stall   i_sample_x/y/z, i_display_axis
//   result    out        o_valid / i_stall   o_pixel_x, o_pixel_y, o_display_value
//   config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One item is in work at a time. The calibration multiplier and the radix-256 long
// divider by the window length are shared by the three axes, which take turns.
// Reset is synchronous and clears the window valid bits, so no clearing pass is needed.
// A result that waits on i_stall holds in the output register while the next item is taken.
module accel_moving_average_to_pixel_unit #(
    parameter int WINDOW_LEN = amap_pkg::WINDOW_LEN_DEF,
    parameter int SCREEN_W   = amap_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H   = amap_pkg::SCREEN_H_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [amap_pkg::SMP_W-1:0]  i_sample_x,
    input  logic signed [amap_pkg::SMP_W-1:0]  i_sample_y,
    input  logic signed [amap_pkg::SMP_W-1:0]  i_sample_z,
    input  logic [1:0]                         i_display_axis,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [$clog2(SCREEN_W)-1:0]        o_pixel_x,
    output logic [$clog2(SCREEN_H)-1:0]        o_pixel_y,
    output logic signed [amap_pkg::Q_W-1:0]    o_display_value,
    input  logic                               i_cfg_we,
    input  amap_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [amap_pkg::Q_W-1:0]           i_cfg_data
);
    import amap_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LEN);
    localparam int PXW   = $clog2(SCREEN_W);
    localparam int PYW   = $clog2(SCREEN_H);

    t_top_state              r_state, n_state;
    t_win_ctl                win_ctl;
    logic                    accept, cal_start, cal_done, pix_load, out_load;
    logic [GAIN_W-1:0]       r_gain;
    logic signed [Q_W-1:0]   r_trim [3];
    logic [1:0]              r_sel;
    logic signed [SUM_W-1:0] sums [3];
    logic signed [Q_W-1:0]   g [3];
    logic signed [Q_W-1:0]   shown;
    logic [PXW-1:0]          pix_x, r_pixel_x;
    logic [PYW-1:0]          pix_y, r_pixel_y;
    logic signed [Q_W-1:0]   r_display;
    logic                    r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            for (int a = 0; a < 3; a++) begin
                r_trim[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:   r_gain    <= i_cfg_data;
                CFG_TRIM_X: r_trim[0] <= $signed(i_cfg_data);
                CFG_TRIM_Y: r_trim[1] <= $signed(i_cfg_data);
                CFG_TRIM_Z: r_trim[2] <= $signed(i_cfg_data);
                default:    r_gain    <= r_gain;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_WIN;
            S_WIN:   n_state = S_CAL;
            S_CAL:   if (cal_done) n_state = S_PIX;
            S_PIX:   n_state = S_OUT;
            S_OUT:   if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall        = (r_state != S_IDLE);
        accept         = (r_state == S_IDLE) && i_valid;
        win_ctl.start  = accept;
        win_ctl.update = (r_state == S_WIN);
        cal_start      = (r_state == S_WIN);
        pix_load       = (r_state == S_PIX);
        out_load       = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel <= i_display_axis;
        end
        if (out_load) begin
            r_pixel_x <= pix_x;
            r_pixel_y <= pix_y;
            r_display <= shown;
        end
    end

    always_comb begin
        case (r_sel)
            AXIS_X:  shown = g[0];
            AXIS_Y:  shown = g[1];
            default: shown = g[2];
        endcase
    end

    amap_window #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_sample_x(i_sample_x),
        .i_sample_y(i_sample_y),
        .i_sample_z(i_sample_z),
        .o_sum     (sums)
    );

    amap_calib #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_calib (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cal_start),
        .i_gain (r_gain),
        .i_trim (r_trim),
        .i_sum  (sums),
        .o_g    (g),
        .o_done (cal_done)
    );

    amap_pixmap #(
        .SPAN(SCREEN_W)
    ) u_pix_x (
        .i_clk (i_clk),
        .i_load(pix_load),
        .i_g   (g[0]),
        .o_pix (pix_x)
    );

    amap_pixmap #(
        .SPAN(SCREEN_H)
    ) u_pix_y (
        .i_clk (i_clk),
        .i_load(pix_load),
        .i_g   (g[1]),
        .o_pix (pix_y)
    );

    assign o_valid         = r_ovalid;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_display_value = r_display;

endmodule

>>> sv/amap_checker.sv
// Port-level checks for the moving-average pixel unit, bound to its top level.
module amap_checker #(
    parameter int SCREEN_W = amap_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = amap_pkg::SCREEN_H_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [$clog2(SCREEN_W)-1:0]       o_pixel_x,
    input logic [$clog2(SCREEN_H)-1:0]       o_pixel_y,
    input logic signed [amap_pkg::Q_W-1:0]   o_display_value
);

    localparam int PXW = $clog2(SCREEN_W);
    localparam int PYW = $clog2(SCREEN_H);

    // A result held back by the consumer stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // A held result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_display_value))
        else $error("result item changed while stalled");

    // Crosshair coordinates never leave the screen.
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_x <= PXW'(SCREEN_W - 1)) && (o_pixel_y <= PYW'(SCREEN_H - 1)))
        else $error("crosshair position off screen");

    // Once an item is taken, the unit is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken back to back");

endmodule

bind accel_moving_average_to_pixel_unit amap_checker #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
) u_amap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_display_value(o_display_value)
);

>>> verif/tb_accel_moving_average_to_pixel_unit.sv
// Self-checking testbench for the accelerometer moving-average crosshair and display unit.
module tb_accel_moving_average_to_pixel_unit;
    import amap_pkg::*;

    localparam int WIN = WINDOW_LEN_DEF;
    localparam int SW = SCREEN_W_DEF;
    localparam int SH = SCREEN_H_DEF;
    localparam int PX_W = $clog2(SW);
    localparam int PY_W = $clog2(SH);
    localparam int ITEM_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [1:0] AXIS_UNUSED = 2'd3;

    typedef struct {
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] z;
        logic [1:0]              axis;
    } t_accel_sample;

    typedef struct {
        logic [PX_W-1:0]       px;
        logic [PY_W-1:0]       py;
        logic signed [Q_W-1:0] disp;
    } t_crosshair;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [SMP_W-1:0] i_sample_x;
    logic signed [SMP_W-1:0] i_sample_y;
    logic signed [SMP_W-1:0] i_sample_z;
    logic [1:0]              i_display_axis;
    logic                    o_valid;
    logic                    i_stall;
    logic [PX_W-1:0]         o_pixel_x;
    logic [PY_W-1:0]         o_pixel_y;
    logic signed [Q_W-1:0]   o_display_value;
    logic                    i_cfg_we;
    t_cfg_idx                i_cfg_idx;
    logic [Q_W-1:0]          i_cfg_data;

    logic signed [SMP_W-1:0] win_mem [WIN][3];
    int                      next_slot;
    longint                  axis_sum [3];
    logic [GAIN_W-1:0]       cal_gain;
    logic signed [Q_W-1:0]   cal_trim [3];

    t_crosshair crosshair_q[$];
    int         mismatch_cnt;
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         rx_hold_req;

    accel_moving_average_to_pixel_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_sample_z      (i_sample_z),
        .i_display_axis  (i_display_axis),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_display_value (o_display_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q -= 1;
        end
        return q;
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint calibrated_g(int a);
        longint scaled;
        scaled = floor_div(axis_sum[a] * longint'(cal_gain), longint'(WIN) * 256);
        return clamp_range(scaled + longint'(cal_trim[a]), Q_MIN, Q_MAX);
    endfunction

    function automatic longint to_screen(longint g, longint span);
        return clamp_range(span / 2 + floor_div(g * (span / 2), 65536), 0, span - 1);
    endfunction

    function automatic t_crosshair predict_crosshair(t_accel_sample s);
        t_crosshair              r;
        logic signed [SMP_W-1:0] v [3];
        longint                  g [3];
        v[0] = s.x;
        v[1] = s.y;
        v[2] = s.z;
        for (int a = 0; a < 3; a++) begin
            axis_sum[a] = axis_sum[a] - longint'(win_mem[next_slot][a]) + longint'(v[a]);
            win_mem[next_slot][a] = v[a];
        end
        next_slot = (next_slot + 1) % WIN;
        for (int a = 0; a < 3; a++) begin
            g[a] = calibrated_g(a);
        end
        r.px = PX_W'(to_screen(g[0], SW));
        r.py = PY_W'(to_screen(g[1], SH));
        if (s.axis == AXIS_X) begin
            r.disp = Q_W'(g[0]);
        end else if (s.axis == AXIS_Y) begin
            r.disp = Q_W'(g[1]);
        end else begin
            r.disp = Q_W'(g[2]);
        end
        return r;
    endfunction

    task automatic send_sample(t_accel_sample s);
        i_valid        <= 1'b1;
        i_sample_x     <= s.x;
        i_sample_y     <= s.y;
        i_sample_z     <= s.z;
        i_display_axis <= s.axis;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        crosshair_q.push_back(predict_crosshair(s));
    endtask

    task automatic sender_pause(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (crosshair_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ITEM_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [Q_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic load_calibration(logic [Q_W-1:0] g, logic [Q_W-1:0] tx,
                                    logic [Q_W-1:0] ty, logic [Q_W-1:0] tz);
        cfg_write(CFG_GAIN, g);
        cfg_write(CFG_TRIM_X, tx);
        cfg_write(CFG_TRIM_Y, ty);
        cfg_write(CFG_TRIM_Z, tz);
        i_cfg_we    <= 1'b0;
        cal_gain    = g;
        cal_trim[0] = tx;
        cal_trim[1] = ty;
        cal_trim[2] = tz;
    endtask

    function automatic logic [Q_W-1:0] pick_trim();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            3: return Q_W'(int'($urandom_range(0, 131072)) - 65536);
            default: return Q_W'($urandom);
        endcase
    endfunction

    task automatic random_calibration();
        logic [Q_W-1:0] g;
        case ($urandom_range(0, 6))
            0: g = '0;
            1: g = 24'hFFFFFF;
            2: g = GAIN_RST;
            3: g = Q_W'($urandom);
            default: g = Q_W'($urandom_range(0, 1 << 18));
        endcase
        load_calibration(g, pick_trim(), pick_trim(), pick_trim());
    endtask

    function automatic logic signed [SMP_W-1:0] pick_extreme();
        return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic t_accel_sample random_sample();
        t_accel_sample s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                s.x = SMP_W'($urandom);
                s.y = SMP_W'($urandom);
                s.z = SMP_W'($urandom);
            end
            5, 6, 7: begin
                s.x = SMP_W'(int'($urandom_range(0, 1024)) - 512);
                s.y = SMP_W'(int'($urandom_range(0, 1024)) - 512);
                s.z = SMP_W'(int'($urandom_range(0, 1024)) + 16000);
            end
            default: begin
                s.x = pick_extreme();
                s.y = pick_extreme();
                s.z = pick_extreme();
            end
        endcase
        s.axis = 2'($urandom_range(0, 3));
        return s;
    endfunction

    // Runs of one repeated sample fill the window so that the means can reach
    // their extremes and the crosshair can pin to the screen edges.
    task automatic send_random_items(int n);
        t_accel_sample run_smp;
        int            run_left;
        run_left = 0;
        for (int k = 0; k < n; k++) begin
            if (run_left == 0 && $urandom_range(0, 19) == 0) begin
                run_smp  = random_sample();
                run_left = $urandom_range(25, 40);
            end
            if (tx_idle_on && $urandom_range(0, 5) == 0) begin
                sender_pause($urandom_range(1, 18));
            end
            if (run_left > 0) begin
                run_smp.axis = 2'($urandom_range(0, 3));
                send_sample(run_smp);
                run_left--;
            end else begin
                send_sample(random_sample());
            end
        end
    endtask

    task automatic test_reset_extremes();
        t_accel_sample s;
        logic [1:0]    axes [4];
        axes = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_UNUSED};
        for (int k = 0; k < 4; k++) begin
            s = '{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh0000, axis: axes[k]};
            send_sample(s);
        end
        for (int k = 0; k < 8; k++) begin
            s = '{x: 16'sh7FFF, y: 16'sh7FFF, z: 16'sh7FFF, axis: axes[k % 4]};
            send_sample(s);
        end
        for (int k = 0; k < 8; k++) begin
            s = '{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000, axis: axes[k % 4]};
            send_sample(s);
        end
    endtask

    task automatic test_calibration_extremes();
        t_accel_sample s;
        wait_for_results();
        load_calibration(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        s = '{x: 16'sh7FFF, y: 16'sh8000, z: 16'sh7FFF, axis: AXIS_X};
        send_sample(s);
        s.axis = AXIS_Y;
        send_sample(s);
        s.axis = AXIS_Z;
        send_sample(s);
        wait_for_results();
        load_calibration('0, 24'h800000, 24'h7FFFFF, 24'h000000);
        s = '{x: 16'sh1234, y: 16'shEDCB, z: 16'sh5555, axis: AXIS_X};
        send_sample(s);
        s.axis = AXIS_UNUSED;
        send_sample(s);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            wait_for_results();
            random_calibration();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            send_random_items(250);
        end
    endtask

    task automatic test_output_hold();
        wait_for_results();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        send_random_items(12);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        wait_for_results();
        random_calibration();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_items(400);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall     <= 1'b0;
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_crosshair want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (crosshair_q.size() == 0) begin
                    $error("unexpected result: pixel_x %0d pixel_y %0d display_value %0d",
                           o_pixel_x, o_pixel_y, o_display_value);
                    mismatch_cnt++;
                end else begin
                    want = crosshair_q.pop_front();
                    if (o_pixel_x !== want.px) begin
                        $error("pixel_x: expected %0d, actual %0d", want.px, o_pixel_x);
                        mismatch_cnt++;
                    end
                    if (o_pixel_y !== want.py) begin
                        $error("pixel_y: expected %0d, actual %0d", want.py, o_pixel_y);
                        mismatch_cnt++;
                    end
                    if (o_display_value !== want.disp) begin
                        $error("display_value: expected %0d, actual %0d",
                               want.disp, o_display_value);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        #(20 * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_sample_x     <= '0;
        i_sample_y     <= '0;
        i_sample_z     <= '0;
        i_display_axis <= AXIS_X;
        i_stall        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_GAIN;
        i_cfg_data     <= '0;
        mismatch_cnt = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        rx_hold_req  = 1'b0;
        next_slot    = 0;
        cal_gain     = GAIN_RST;
        for (int a = 0; a < 3; a++) begin
            axis_sum[a] = 0;
            cal_trim[a] = '0;
            for (int k = 0; k < WIN; k++) begin
                win_mem[k][a] = '0;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_extremes();
        test_calibration_extremes();
        test_random_phases();
        test_output_hold();
        test_back_to_back();
        wait_for_results();

        if (mismatch_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
sv/amap_pkg.sv
sv/amap_ram.sv
sv/amap_window.sv
sv/amap_calib.sv
sv/amap_pixmap.sv
sv/accel_moving_average_to_pixel_unit.sv
sv/amap_checker.sv
verif/tb_accel_moving_average_to_pixel_unit.sv
